// File: design/sbsr_pkg.sv
// ----------------------------------------------------------------------------
// sbsr_pkg: shared types and constants of the steering board serial responder
// Word formats of the request and reply channels and the protocol byte codes.
// ----------------------------------------------------------------------------
package sbsr_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_POWER = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_1        = 8'h31;
    localparam logic [7:0] CH_6        = 8'h36;

    localparam logic [9:0]  POS_MAX     = 10'd1023;
    localparam int          REPLY_DEPTH = 1024;
    localparam int          PEND_W      = $clog2(REPLY_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         write_byte;
        logic               self_check_request;
        logic signed [15:0] wheel_raw;
        logic               motor_running;
    } t_in_word;

    typedef struct packed {
        logic [7:0]        reply_byte;
        logic              reply_valid;
        logic [PEND_W-1:0] reply_pending;
    } t_out_word;

endpackage

// File: design/steering_board_serial_responder.sv
// ----------------------------------------------------------------------------
// steering_board_serial_responder: emulated steering board serial responder
// Frames host bytes, keeps the reply queue in a RAM and answers byte reads.
// ----------------------------------------------------------------------------
// One request word is taken at a time. A plain write or a clear goes from
// idle straight to the done state, a read from a non-empty queue passes
// through a RAM read state, and a completed frame or a power report pushes its
// reply bytes before done. A read that finds the queue empty scales the wheel
// sample in a ten-step divider and writes the refill bytes one per cycle
// through the single RAM write port. The next request is taken while a reply
// word still waits at the output.
module steering_board_serial_responder
    import sbsr_pkg::*;
#(
    parameter int FRAME_LENGTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(REPLY_DEPTH);
    localparam int CW = $clog2(REPLY_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int FW = $clog2(FRAME_LENGTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_PUSH  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_POP   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        SEQ_STATUS,
        SEQ_RUN,
        SEQ_STOP,
        SEQ_CHECK,
        SEQ_POS
    } t_seq;

    function automatic logic [7:0] push_byte(t_seq seq, logic [3:0] idx, logic [9:0] pos);
        logic [71:0] v;
        logic [7:0]  b;
        begin
            v = '0;
            case (seq)
                SEQ_STATUS: v[71:48] = {CH_E, CH_0, CH_0};
                SEQ_RUN:    v[71:48] = {CH_C, CH_0, CH_1};
                SEQ_STOP:   v[71:48] = {CH_C, CH_0, CH_6};
                SEQ_CHECK:  v = {CH_E, CH_0, CH_0, CH_C, CH_0, CH_6,
                                 CH_H, {6'd0, pos[9:8]}, pos[7:0]};
                default:    v[71:48] = {CH_H, {6'd0, pos[9:8]}, pos[7:0]};
            endcase
            case (idx)
                4'd0:    b = v[71:64];
                4'd1:    b = v[63:56];
                4'd2:    b = v[55:48];
                4'd3:    b = v[47:40];
                4'd4:    b = v[39:32];
                4'd5:    b = v[31:24];
                4'd6:    b = v[23:16];
                4'd7:    b = v[15:8];
                default: b = v[7:0];
            endcase
            return b;
        end
    endfunction

    function automatic logic [3:0] seq_last(t_seq seq);
        return (seq == SEQ_CHECK) ? 4'd8 : 4'd2;
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [FW-1:0]   r_fill, n_fill;
    t_seq            r_seq, n_seq;
    logic [3:0]      r_idx, n_idx;
    logic [9:0]      r_pos, n_pos;
    logic            r_pop, n_pop;
    logic [7:0]      r_res_byte, n_res_byte;
    logic            r_res_valid, n_res_valid;
    logic [15:0]     r_full_scale;
    t_out_word       r_out;
    logic            r_out_valid;

    logic            w_in_fire;
    logic            w_out_fire;
    logic            w_load;
    logic            w_we;
    logic [SW-1:0]   w_sum;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_head_inc;
    logic [FW-1:0]   w_fill_inc;
    logic [7:0]      w_push;
    logic [7:0]      w_rdata;
    logic            w_scale_start;
    logic            w_scale_done;
    logic [9:0]      w_scale_pos;

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = r_out_valid && i_out_ready;
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign w_sum      = SW'(r_head) + SW'(r_count);
    assign w_waddr    = (w_sum >= SW'(REPLY_DEPTH)) ? AW'(w_sum - SW'(REPLY_DEPTH))
                                                    : AW'(w_sum);
    assign w_head_inc = (r_head == AW'(REPLY_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_fill_inc = r_fill + 1'b1;
    assign w_push     = push_byte(r_seq, r_idx, r_pos);

    sbsr_ram #(
        .WIDTH (8),
        .DEPTH (REPLY_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_push),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    sbsr_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_scale_start),
        .i_raw        (i_in_word.wheel_raw),
        .i_full_scale (r_full_scale),
        .o_done       (w_scale_done),
        .o_pos        (w_scale_pos)
    );

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_fill        = r_fill;
        n_seq         = r_seq;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_pop         = r_pop;
        n_res_byte    = r_res_byte;
        n_res_valid   = r_res_valid;
        w_we          = 1'b0;
        w_scale_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_res_byte  = 8'd0;
                    n_res_valid = 1'b0;
                    n_pop       = 1'b0;
                    n_idx       = 4'd0;
                    unique case (i_in_word.action)
                        ACT_WRITE: begin
                            n_state = ST_DONE;
                            if (r_fill != '0 || i_in_word.write_byte == HEADER_BYTE) begin
                                if (w_fill_inc >= FW'(FRAME_LENGTH)) begin
                                    n_fill = '0;
                                    if (SW'(r_count) + SW'(3) > SW'(REPLY_DEPTH)) begin
                                        n_head  = '0;
                                        n_count = '0;
                                    end
                                    n_seq   = SEQ_STATUS;
                                    n_state = ST_PUSH;
                                end else begin
                                    n_fill = w_fill_inc;
                                end
                            end
                        end
                        ACT_READ: begin
                            if (r_count == '0) begin
                                n_seq         = i_in_word.self_check_request ? SEQ_CHECK
                                                                             : SEQ_POS;
                                n_pop         = 1'b1;
                                w_scale_start = 1'b1;
                                n_state       = ST_SCALE;
                            end else begin
                                n_state = ST_READ;
                            end
                        end
                        ACT_POWER: begin
                            n_head  = '0;
                            n_count = '0;
                            n_seq   = i_in_word.motor_running ? SEQ_RUN : SEQ_STOP;
                            n_state = ST_PUSH;
                        end
                        default: begin
                            n_fill  = '0;
                            n_head  = '0;
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCALE: begin
                if (w_scale_done) begin
                    n_pos   = w_scale_pos;
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (SW'(r_count) < SW'(REPLY_DEPTH)) begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_idx = r_idx + 4'd1;
                if (r_idx == seq_last(r_seq)) begin
                    n_state = r_pop ? ST_POP : ST_DONE;
                end
            end
            ST_READ: begin
                n_res_byte  = w_rdata;
                n_res_valid = 1'b1;
                n_head      = w_head_inc;
                n_count     = r_count - 1'b1;
                n_state     = ST_DONE;
            end
            ST_POP: begin
                n_res_byte  = push_byte(r_seq, 4'd0, r_pos);
                n_res_valid = 1'b1;
                n_head      = w_head_inc;
                n_count     = r_count - 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_fill       <= '0;
            r_full_scale <= 16'd255;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_fill  <= n_fill;
            if (i_cfg_valid && o_cfg_ready) begin
                r_full_scale <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
        r_seq       <= n_seq;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_pop       <= n_pop;
        r_res_byte  <= n_res_byte;
        r_res_valid <= n_res_valid;
        if (w_load) begin
            r_out.reply_byte    <= r_res_byte;
            r_out.reply_valid   <= r_res_valid;
            r_out.reply_pending <= PEND_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_count) <= SW'(REPLY_DEPTH))
        else $error("Reply queue count exceeds its depth.");

    a_scale_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scale_done |-> r_state == ST_SCALE)
        else $error("Scaler finished while no refill was waiting for it.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_POP |-> r_count != '0)
        else $error("Refill pop found an empty queue.");

    a_clear_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && i_in_word.action == ACT_CLEAR |=> r_count == '0 && r_fill == '0)
        else $error("Clear request left queue or frame state behind.");

endmodule

// File: design/sbsr_ram.sv
// ----------------------------------------------------------------------------
// sbsr_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sbsr_scale.sv
// ----------------------------------------------------------------------------
// sbsr_scale: wheel position scaler
// Clamps the raw sample to the full scale and computes raw * 1023 / full_scale
// with a multiply state and a ten-step restoring divider.
// ----------------------------------------------------------------------------
module sbsr_scale
    import sbsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_raw,
    input  logic [15:0]        i_full_scale,
    output logic               o_done,
    output logic [9:0]         o_pos
);

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_MUL  = 4'b0010,
        SC_DIV  = 4'b0100,
        SC_DONE = 4'b1000
    } t_sc_state;

    t_sc_state   r_state, n_state;
    logic [15:0] r_max, n_max;
    logic [15:0] r_clamp, n_clamp;
    logic [15:0] r_rem, n_rem;
    logic [9:0]  r_low, n_low;
    logic [3:0]  r_cnt, n_cnt;

    logic [15:0] w_fs_eff;
    logic [25:0] w_prod;
    logic [16:0] w_trial;
    logic        w_take;

    assign w_fs_eff = (i_full_scale == 16'd0) ? 16'd1 : i_full_scale;
    assign w_prod   = 26'(r_clamp) * 26'(POS_MAX);
    assign w_trial  = {r_rem, r_low[9]};
    assign w_take   = w_trial >= {1'b0, r_max};

    always_comb begin
        n_state = r_state;
        n_max   = r_max;
        n_clamp = r_clamp;
        n_rem   = r_rem;
        n_low   = r_low;
        n_cnt   = r_cnt;
        unique case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_max = w_fs_eff;
                    if (i_raw[15]) begin
                        n_clamp = 16'd0;
                    end else if ($unsigned(i_raw) > w_fs_eff) begin
                        n_clamp = w_fs_eff;
                    end else begin
                        n_clamp = $unsigned(i_raw);
                    end
                    n_state = SC_MUL;
                end
            end
            SC_MUL: begin
                n_rem   = w_prod[25:10];
                n_low   = w_prod[9:0];
                n_cnt   = 4'd0;
                n_state = SC_DIV;
            end
            SC_DIV: begin
                n_rem = w_take ? 16'(w_trial - {1'b0, r_max}) : w_trial[15:0];
                n_low = {r_low[8:0], w_take};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd9) begin
                    n_state = SC_DONE;
                end
            end
            SC_DONE: begin
                n_state = SC_IDLE;
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_max   <= n_max;
        r_clamp <= n_clamp;
        r_rem   <= n_rem;
        r_low   <= n_low;
        r_cnt   <= n_cnt;
    end

    assign o_done = r_state == SC_DONE;
    assign o_pos  = r_low;

endmodule
